// ===== sv/fspt_pkg.sv =====
// shared types and constants of the force sensor probe trigger
// action codes, internal command codes, register indexes, fixed field widths
// no dependencies
package fspt_pkg;

	localparam int ACTION_BITS    = 3;
	localparam int CFG_IDX_BITS   = 4;
	localparam int CFG_DATA_BITS  = 12;
	localparam int LEVEL_BITS     = 12;
	localparam int DEBOUNCE_BITS  = 8;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_BITS      = 1;
	localparam int QCNT_BITS      = 2;
	localparam int TARE_TRIM      = 2;

	localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 8'd2;

	localparam logic [ACTION_BITS-1:0] ACT_SAMPLE    = 3'd0;
	localparam logic [ACTION_BITS-1:0] ACT_ARM       = 3'd1;
	localparam logic [ACTION_BITS-1:0] ACT_DISARM    = 3'd2;
	localparam logic [ACTION_BITS-1:0] ACT_TARE      = 3'd3;
	localparam logic [ACTION_BITS-1:0] ACT_TARE_END  = 3'd4;

	localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE_THRESHOLD = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_OFFSET      = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIGGER_OFFSET  = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_COUNT  = 4'd3;

	typedef enum logic [2:0] {
		CMD_SAMPLE,
		CMD_ARM,
		CMD_DISARM,
		CMD_TARE,
		CMD_TARE_END,
		CMD_NOP
	} cmd_t;

	function automatic cmd_t classify(logic [ACTION_BITS-1:0] action);
		cmd_t c;
		unique case (action)
			ACT_SAMPLE:   c = CMD_SAMPLE;
			ACT_ARM:      c = CMD_ARM;
			ACT_DISARM:   c = CMD_DISARM;
			ACT_TARE:     c = CMD_TARE;
			ACT_TARE_END: c = CMD_TARE_END;
			default:      c = CMD_NOP;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/fspt_if.sv =====
// channel interfaces of the force sensor probe trigger: sample items,
// result items and configuration writes
// depends on fspt_pkg for field widths
interface fspt_in_if #(parameter int SAMPLE_BITS = 12);
	import fspt_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [ACTION_BITS-1:0] action;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink   (input valid, input action, input sample, output ready);
endinterface

interface fspt_out_if #(parameter int SAMPLE_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic                   tripped;
	logic [SAMPLE_BITS-1:0] peak_amplitude;
	logic [SAMPLE_BITS-1:0] peak_slope;
	logic [SAMPLE_BITS-1:0] noise_peak_to_peak;
	logic [SAMPLE_BITS-1:0] slope_noise;
	logic [SAMPLE_BITS-1:0] baseline;
	logic [SAMPLE_BITS-1:0] filtered;

	modport source (output valid, output tripped, output peak_amplitude, output peak_slope,
		output noise_peak_to_peak, output slope_noise, output baseline, output filtered,
		input ready);
	modport sink (input valid, input tripped, input peak_amplitude, input peak_slope,
		input noise_peak_to_peak, input slope_noise, input baseline, input filtered,
		output ready);
endinterface

interface fspt_cfg_if;
	import fspt_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/fspt_front.sv =====
// front end: accepts sample items, decodes the action into a command
// and keeps them in a short queue for the back end
// depends on fspt_pkg and fspt_if
module fspt_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	fspt_in_if.sink                samples,
	output logic                   q_valid,
	output fspt_pkg::cmd_t         q_cmd,
	output logic [SAMPLE_BITS-1:0] q_sample,
	input  logic                   q_ready
);
	import fspt_pkg::*;

	cmd_t                   cmd_q    [QUEUE_DEPTH];
	logic [SAMPLE_BITS-1:0] sample_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;
	logic                   push;
	logic                   pop;

	assign samples.ready = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
	assign push          = samples.valid && samples.ready;
	assign q_valid       = (cnt_q != '0);
	assign pop           = q_valid && q_ready;
	assign q_cmd         = cmd_q[rd_ptr_q];
	assign q_sample      = sample_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q]    <= classify(samples.action);
			sample_q[wr_ptr_q] <= samples.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			priority if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== sv/fspt_div.sv =====
// serial restoring divider used for the tare mean, one quotient bit per cycle
// depends on nothing outside this file
module fspt_div #(
	parameter int DIVIDEND_BITS = 28,
	parameter int DIVISOR_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);
	localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

	logic [DIVISOR_BITS:0]    rem_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  dvs_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DIVISOR_BITS:0]    shifted;
	logic                     ge;

	// remainder stays below the divisor, so its top bit is free for the shift
	assign shifted  = {rem_q[DIVISOR_BITS-1:0], quo_q[DIVIDEND_BITS-1]};
	assign ge       = (shifted >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DIVIDEND_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/fspt_back.sv =====
// back end: filter, trigger and tare state, configuration registers,
// tare-end mean through the serial divider, result register
// depends on fspt_pkg, fspt_if and fspt_div
module fspt_back #(
	parameter int SAMPLE_BITS     = 12,
	parameter int TARE_COUNT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  fspt_pkg::cmd_t         q_cmd,
	input  logic [SAMPLE_BITS-1:0] q_sample,
	output logic                   q_ready,
	fspt_cfg_if.sink               cfg,
	fspt_out_if.source             results
);
	import fspt_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int TB   = TARE_COUNT_BITS;
	localparam int SW   = SAMPLE_BITS + TARE_COUNT_BITS;
	localparam int CMPW = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [LEVEL_BITS-1:0]    slope_thr_q, min_off_q, trig_off_q;
	logic [DEBOUNCE_BITS-1:0] debounce_q;

	// block state and next values
	logic                     filt_rdy_q, filt_rdy_d;
	logic [SB-1:0]            filt_q, filt_d, prev_q, prev_d, base_q, base_d;
	logic                     armed_q, armed_d, trip_q, trip_d;
	logic [DEBOUNCE_BITS-1:0] hits_q, hits_d;
	logic [SB-1:0]            mstep_q, mstep_d, mlevel_q, mlevel_d;
	logic [SB-1:0]            cap_amp_q, cap_amp_d, cap_slope_q, cap_slope_d;
	logic                     taring_q, taring_d;
	logic [SW-1:0]            tsum_q, tsum_d;
	logic [SB-1:0]            tmin_q, tmin_d, tmax_q, tmax_d, tstep_q, tstep_d;
	logic [SB-1:0]            tprev_q, tprev_d;
	logic [TB-1:0]            tcnt_q, tcnt_d;
	logic [SB-1:0]            nspan_q, nspan_d, nstep_q, nstep_d;

	// result register
	logic                     out_valid_q;
	logic                     r_trip_q;
	logic [SB-1:0]            r_amp_q, r_slope_q, r_span_q, r_step_q, r_base_q, r_filt_q;

	logic                     out_free, pop, cnt_nz, apply_item, apply_end, div_start, div_done;
	logic [SW-1:0]            div_dividend, div_quotient;
	logic [TB-1:0]            div_divisor;
	logic [SB-1:0]            end_base;

	assign cfg.ready  = 1'b1;
	assign out_free   = !out_valid_q || results.ready;
	assign pop        = (state_q == ST_IDLE) && q_valid && out_free;
	assign q_ready    = pop;
	assign cnt_nz     = (tcnt_q != '0);
	assign div_start  = pop && (q_cmd == CMD_TARE_END) && cnt_nz;
	assign apply_item = pop && (q_cmd != CMD_TARE_END);
	// empty tare ends at once, otherwise after the divider
	assign apply_end  = (pop && (q_cmd == CMD_TARE_END) && !cnt_nz)
		|| ((state_q == ST_DONE) && out_free);
	assign end_base   = cnt_nz ? div_quotient[SB-1:0] : '0;

	// trimmed sum over count minus two, or plain mean for one or two samples
	always_comb begin
		if (tcnt_q > TB'(TARE_TRIM)) begin
			div_dividend = tsum_q - SW'(tmin_q) - SW'(tmax_q);
			div_divisor  = tcnt_q - TB'(TARE_TRIM);
		end else begin
			div_dividend = tsum_q;
			div_divisor  = tcnt_q;
		end
	end

	fspt_div #(
		.DIVIDEND_BITS (SW),
		.DIVISOR_BITS  (TB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (div_start) state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		logic [SB-1:0]            f_new, pv, step, offset;
		logic [SB:0]              dn;
		logic                     hit;
		logic [DEBOUNCE_BITS-1:0] h_new;
		logic [SB-1:0]            d;

		filt_rdy_d  = filt_rdy_q;
		filt_d      = filt_q;
		prev_d      = prev_q;
		base_d      = base_q;
		armed_d     = armed_q;
		trip_d      = trip_q;
		hits_d      = hits_q;
		mstep_d     = mstep_q;
		mlevel_d    = mlevel_q;
		cap_amp_d   = cap_amp_q;
		cap_slope_d = cap_slope_q;
		taring_d    = taring_q;
		tsum_d      = tsum_q;
		tmin_d      = tmin_q;
		tmax_d      = tmax_q;
		tstep_d     = tstep_q;
		tprev_d     = tprev_q;
		tcnt_d      = tcnt_q;
		nspan_d     = nspan_q;
		nstep_d     = nstep_q;

		f_new  = '0;
		pv     = '0;
		step   = '0;
		offset = '0;
		dn     = '0;
		hit    = 1'b0;
		h_new  = '0;
		d      = '0;

		if (apply_item) begin
			unique case (q_cmd)
				CMD_SAMPLE: begin
					if (!taring_q) begin
						priority if (!filt_rdy_q) begin
							f_new = q_sample;
						end else if (q_sample >= filt_q) begin
							f_new = filt_q + ((q_sample - filt_q) >> 2);
						end else begin
							// round the downward step away from zero
							dn    = {1'b0, filt_q - q_sample} + (SB+1)'(3);
							f_new = filt_q - SB'(dn[SB:2]);
						end
						pv         = filt_rdy_q ? prev_q : q_sample;
						step       = (f_new >= pv) ? (f_new - pv) : (pv - f_new);
						filt_d     = f_new;
						prev_d     = f_new;
						filt_rdy_d = 1'b1;
						if (armed_q) begin
							mstep_d  = (step > mstep_q) ? step : mstep_q;
							mlevel_d = (f_new > mlevel_q) ? f_new : mlevel_q;
							offset   = (f_new > base_q) ? (f_new - base_q) : '0;
							hit = (CMPW'(offset) >= CMPW'(trig_off_q))
								|| ((CMPW'(offset) >= CMPW'(min_off_q))
								&& (CMPW'(step) >= CMPW'(slope_thr_q)));
							if (hit) begin
								h_new  = (hits_q < debounce_q) ? (hits_q + 1'b1) : hits_q;
								hits_d = h_new;
								if (!trip_q && (h_new >= debounce_q)) begin
									trip_d      = 1'b1;
									cap_amp_d   = (mlevel_d > base_q) ? (mlevel_d - base_q) : '0;
									cap_slope_d = mstep_d;
								end
							end else begin
								hits_d = '0;
							end
						end
					end
				end
				CMD_ARM: begin
					armed_d     = 1'b1;
					trip_d      = 1'b0;
					hits_d      = '0;
					mstep_d     = '0;
					mlevel_d    = filt_rdy_q ? filt_q : base_q;
					cap_amp_d   = '0;
					cap_slope_d = '0;
				end
				CMD_DISARM: begin
					armed_d = 1'b0;
					trip_d  = 1'b0;
					hits_d  = '0;
				end
				CMD_TARE: begin
					// first tare sample disarms and starts from clear accumulators
					if (!taring_q) begin
						armed_d  = 1'b0;
						trip_d   = 1'b0;
						hits_d   = '0;
						tsum_d   = '0;
						tmin_d   = '1;
						tmax_d   = '0;
						tstep_d  = '0;
						tprev_d  = '0;
						tcnt_d   = '0;
						taring_d = 1'b1;
					end
					if (!(&tcnt_d)) begin
						if (q_sample < tmin_d) tmin_d = q_sample;
						if (q_sample > tmax_d) tmax_d = q_sample;
						tsum_d = tsum_d + SW'(q_sample);
						if (tcnt_d != '0) begin
							d = (q_sample >= tprev_d) ? (q_sample - tprev_d) : (tprev_d - q_sample);
							if (d > tstep_d) tstep_d = d;
						end
						tprev_d = q_sample;
						tcnt_d  = tcnt_d + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (apply_end) begin
			armed_d    = 1'b0;
			trip_d     = 1'b0;
			hits_d     = '0;
			base_d     = end_base;
			nspan_d    = cnt_nz ? (tmax_q - tmin_q) : '0;
			nstep_d    = cnt_nz ? tstep_q : '0;
			filt_d     = end_base;
			prev_d     = end_base;
			filt_rdy_d = 1'b1;
			taring_d   = 1'b0;
			tsum_d     = '0;
			tmin_d     = '1;
			tmax_d     = '0;
			tstep_d    = '0;
			tprev_d    = '0;
			tcnt_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slope_thr_q <= '0;
			min_off_q   <= '0;
			trig_off_q  <= '0;
			debounce_q  <= DEBOUNCE_RESET;
			filt_rdy_q  <= 1'b0;
			filt_q      <= '0;
			prev_q      <= '0;
			base_q      <= '0;
			armed_q     <= 1'b0;
			trip_q      <= 1'b0;
			hits_q      <= '0;
			mstep_q     <= '0;
			mlevel_q    <= '0;
			cap_amp_q   <= '0;
			cap_slope_q <= '0;
			taring_q    <= 1'b0;
			tsum_q      <= '0;
			tmin_q      <= '1;
			tmax_q      <= '0;
			tstep_q     <= '0;
			tprev_q     <= '0;
			tcnt_q      <= '0;
			nspan_q     <= '0;
			nstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			filt_rdy_q  <= filt_rdy_d;
			filt_q      <= filt_d;
			prev_q      <= prev_d;
			base_q      <= base_d;
			armed_q     <= armed_d;
			trip_q      <= trip_d;
			hits_q      <= hits_d;
			mstep_q     <= mstep_d;
			mlevel_q    <= mlevel_d;
			cap_amp_q   <= cap_amp_d;
			cap_slope_q <= cap_slope_d;
			taring_q    <= taring_d;
			tsum_q      <= tsum_d;
			tmin_q      <= tmin_d;
			tmax_q      <= tmax_d;
			tstep_q     <= tstep_d;
			tprev_q     <= tprev_d;
			tcnt_q      <= tcnt_d;
			nspan_q     <= nspan_d;
			nstep_q     <= nstep_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_SLOPE_THRESHOLD: slope_thr_q <= cfg.data;
					REG_MIN_OFFSET:      min_off_q   <= cfg.data;
					REG_TRIGGER_OFFSET:  trig_off_q  <= cfg.data;
					REG_DEBOUNCE_COUNT:  debounce_q  <= cfg.data[DEBOUNCE_BITS-1:0];
					default: begin
					end
				endcase
			end
			priority if (apply_item || apply_end) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	// result snapshot of the state after the item
	always_ff @(posedge clk) begin
		if (apply_item || apply_end) begin
			r_trip_q  <= trip_d;
			r_amp_q   <= cap_amp_d;
			r_slope_q <= cap_slope_d;
			r_span_q  <= nspan_d;
			r_step_q  <= nstep_d;
			r_base_q  <= base_d;
			r_filt_q  <= filt_d;
		end
	end

	assign results.valid              = out_valid_q;
	assign results.tripped            = r_trip_q;
	assign results.peak_amplitude     = r_amp_q;
	assign results.peak_slope         = r_slope_q;
	assign results.noise_peak_to_peak = r_span_q;
	assign results.slope_noise        = r_step_q;
	assign results.baseline           = r_base_q;
	assign results.filtered           = r_filt_q;

endmodule

// ===== sv/force_sensor_probe_trigger.sv =====
// top level of the force sensor probe trigger
// depends on fspt_pkg, fspt_if, fspt_front and fspt_back
//
// channels: samples carries action and raw sample, results carries one result
// item per sample item (trip flag, captured peaks, tare noise, baseline,
// filtered value), cfg writes the four threshold and debounce registers and
// is always ready.
// every sample item yields exactly one result, in order. ordinary actions pass
// through the front queue and the result register, and the block sustains
// one item per cycle while results is ready and no tare divide is running.
// a tare end with samples runs the trimmed mean through a serial divider, one
// quotient bit per cycle; its result is registered once the divider is done and
// the result register is free; items behind it wait in the two-entry queue.
// when results stalls, the finished result stays in the output register; the
// back end stops and the front queue keeps accepting until it is full.
// reset clears all filter, trigger and tare state, sets the debounce count to
// two and the other registers to zero; there is no clearing pass.
module force_sensor_probe_trigger #(
	parameter int SAMPLE_BITS     = 12,
	parameter int TARE_COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	fspt_in_if.sink    samples,
	fspt_out_if.source results,
	fspt_cfg_if.sink   cfg
);
	import fspt_pkg::*;

	logic                   q_valid;
	logic                   q_ready;
	cmd_t                   q_cmd;
	logic [SAMPLE_BITS-1:0] q_sample;

	fspt_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_sample (q_sample),
		.q_ready  (q_ready)
	);

	fspt_back #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.TARE_COUNT_BITS (TARE_COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_sample (q_sample),
		.q_ready  (q_ready),
		.cfg      (cfg),
		.results  (results)
	);

endmodule

// ===== sv/fspt_checker.sv =====
// port-level checks of the force sensor probe trigger and their bind
// depends on force_sensor_probe_trigger
module fspt_checker #(
	parameter int SAMPLE_BITS = 12
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   tripped,
	input logic [SAMPLE_BITS-1:0] peak_amplitude,
	input logic [SAMPLE_BITS-1:0] baseline,
	input logic [SAMPLE_BITS-1:0] filtered,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(tripped) && $stable(peak_amplitude)
			&& $stable(baseline) && $stable(filtered))
		else $error("result payload changed while stalled");

	// no result offered straight out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered right after reset");

	// configuration writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind force_sensor_probe_trigger fspt_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_fspt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.tripped        (results.tripped),
	.peak_amplitude (results.peak_amplitude),
	.baseline       (results.baseline),
	.filtered       (results.filtered),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready)
);
